### hw/rtl/assert_macros.svh
// Shared assertion macros for the interpolator checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sampled on the rising clock, off while reset is high.
`define PLI_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pli assertion failed");

// Sampled on the rising clock, also during reset.
`define PLI_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pli assertion failed");

`endif

### hw/rtl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = 7;
   localparam int INDEX_W     = 6;
   localparam int DATA_W      = 32;
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_type_type;

   typedef enum logic [1:0] {
      STAT_INTERP = 2'd0,
      STAT_FIRST  = 2'd1,
      STAT_LAST   = 2'd2
   } range_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_LAST,
      ST_DIR,
      ST_SCAN,
      ST_MAG,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_OUT
   } state_type;

endpackage

### hw/rtl/piecewise_linear_interpolator_top.sv
// Load beat: written to the table on accept, req_ready stays high, no response.
// Query beat: response clamped to the first entry, clamped to the last entry in use, or
// interpolated at the bracket found; one table read per scanned entry plus a 32-step
// restoring divider.
// Reset (synchronous, active high) clears control and sets table_length to 1;
// table contents stay undefined until loaded.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top import pli_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [INDEX_W-1:0]       req_entry_index,
   input  logic signed [DATA_W-1:0] req_entry_x,
   input  logic signed [DATA_W-1:0] req_entry_y,
   input  logic signed [DATA_W-1:0] req_query_x,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_interp_value,
   output logic [1:0]               rsp_range_status,
   input  logic                     csr_wr_en,
   input  logic [LEN_W-1:0]         csr_wr_data
);

   logic signed [DATA_W-1:0] x_mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] y_mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] x_rd_ff;
   logic signed [DATA_W-1:0] y_rd_ff;
   logic [ADDR_W-1:0]        rd_addr;

   state_type                state_ff;
   state_type                state_in;
   logic [LEN_W-1:0]         table_length_ff;
   logic [ADDR_W-1:0]        len_last;
   logic [ADDR_W-1:0]        n_last_ff;
   logic [ADDR_W-1:0]        a_ff;
   logic [ADDR_W-1:0]        c_ff;
   logic signed [DATA_W-1:0] q_ff;
   logic signed [DATA_W-1:0] first_x_ff;
   logic signed [DATA_W-1:0] prev_x_ff;
   logic signed [DATA_W-1:0] prev_y_ff;
   logic signed [DATA_W-1:0] cur_x_ff;
   logic signed [DATA_W-1:0] cur_y_ff;
   logic                     incr_ff;
   logic [DATA_W-1:0]        tm_ff;
   logic [DATA_W-1:0]        dym_ff;
   logic [DATA_W-1:0]        dxm_ff;
   logic                     neg_ff;
   logic [DATA_W-1:0]        rem_ff;
   logic [DATA_W-1:0]        quo_ff;
   logic [DIV_CNT_W-1:0]     cnt_ff;
   logic [DATA_W-1:0]        res_ff;
   range_status_type         stat_ff;
   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_value_ff;
   range_status_type         rsp_status_ff;

   logic                     req_fire;
   logic                     load_fire;
   logic                     query_fire;
   logic                     scan_hit;
   logic                     rsp_free;
   logic signed [DATA_W:0]   t_diff;
   logic signed [DATA_W:0]   dy_diff;
   logic signed [DATA_W:0]   dx_diff;
   logic [2*DATA_W-1:0]      prod;
   logic [DATA_W:0]          rem_sh;
   logic [DATA_W:0]          rem_sub;
   logic                     div_ge;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign load_fire  = req_fire && (req_type == REQ_LOAD)
                       && (32'(req_entry_index) < TABLE_DEPTH);
   assign query_fire = req_fire && (req_type == REQ_QUERY);
   assign scan_hit   = incr_ff ? (x_rd_ff < q_ff) : (x_rd_ff > q_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign t_diff  = {q_ff[DATA_W-1], q_ff} - {prev_x_ff[DATA_W-1], prev_x_ff};
   assign dy_diff = {cur_y_ff[DATA_W-1], cur_y_ff} - {prev_y_ff[DATA_W-1], prev_y_ff};
   assign dx_diff = {cur_x_ff[DATA_W-1], cur_x_ff} - {prev_x_ff[DATA_W-1], prev_x_ff};
   assign prod    = tm_ff * dym_ff;
   assign rem_sh  = {rem_ff, quo_ff[DATA_W-1]};
   assign rem_sub = rem_sh - {1'b0, dxm_ff};
   assign div_ge  = (rem_sh >= {1'b0, dxm_ff});

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_range_status = rsp_status_ff;

   always_comb begin
      if (table_length_ff == '0) begin
         len_last = '0;
      end else if (32'(table_length_ff) > TABLE_DEPTH) begin
         len_last = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         len_last = ADDR_W'(table_length_ff - LEN_W'(1));
      end
   end

   // table memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_fire) begin
         x_mem[ADDR_W'(req_entry_index)] <= req_entry_x;
         y_mem[ADDR_W'(req_entry_index)] <= req_entry_y;
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         table_length_ff <= LEN_W'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            table_length_ff <= csr_wr_data;
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = ST_RD_LAST;
            end
         end
         ST_RD_LAST: begin
            rd_addr  = n_last_ff;
            state_in = ST_DIR;
         end
         ST_DIR: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr = a_ff;
            if (scan_hit) begin
               if (c_ff == n_last_ff) begin
                  state_in = ST_OUT;
               end
            end else if (c_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               q_ff      <= req_query_x;
               n_last_ff <= len_last;
            end
         end
         ST_RD_LAST: begin
            first_x_ff <= x_rd_ff;
         end
         ST_DIR: begin
            incr_ff <= (first_x_ff < x_rd_ff);
            a_ff    <= ADDR_W'(1);
            c_ff    <= '0;
         end
         ST_SCAN: begin
            a_ff <= a_ff + ADDR_W'(1);
            if (scan_hit) begin
               prev_x_ff <= x_rd_ff;
               prev_y_ff <= y_rd_ff;
               c_ff      <= c_ff + ADDR_W'(1);
               if (c_ff == n_last_ff) begin
                  res_ff  <= y_rd_ff;
                  stat_ff <= STAT_LAST;
               end
            end else begin
               cur_x_ff <= x_rd_ff;
               cur_y_ff <= y_rd_ff;
               if (c_ff == '0) begin
                  res_ff  <= y_rd_ff;
                  stat_ff <= STAT_FIRST;
               end
            end
         end
         ST_MAG: begin
            tm_ff  <= t_diff[DATA_W] ? DATA_W'(-t_diff) : t_diff[DATA_W-1:0];
            dym_ff <= dy_diff[DATA_W] ? DATA_W'(-dy_diff) : dy_diff[DATA_W-1:0];
            dxm_ff <= dx_diff[DATA_W] ? DATA_W'(-dx_diff) : dx_diff[DATA_W-1:0];
            neg_ff <= t_diff[DATA_W] ^ dy_diff[DATA_W] ^ dx_diff[DATA_W];
         end
         ST_MUL: begin
            rem_ff <= prod[2*DATA_W-1:DATA_W];
            quo_ff <= prod[DATA_W-1:0];
            cnt_ff <= DIV_CNT_W'(DIV_STEPS - 1);
         end
         ST_DIV: begin
            rem_ff <= div_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], div_ge};
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         end
         ST_SUM: begin
            res_ff  <= neg_ff ? (prev_y_ff - quo_ff) : (prev_y_ff + quo_ff);
            stat_ff <= STAT_INTERP;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_value_ff  <= res_ff;
               rsp_status_ff <= stat_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/pli_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pli_checker import pli_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_type,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_interp_value,
   input logic [1:0]               rsp_range_status
);

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interp_value)
         && $stable(rsp_range_status);
   endproperty

   property p_status_code;
      rsp_valid |-> (rsp_range_status == STAT_INTERP) || (rsp_range_status == STAT_FIRST)
         || (rsp_range_status == STAT_LAST);
   endproperty

   `PLI_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_ready)
   `PLI_ASSERT(a_rsp_hold, p_rsp_hold)
   `PLI_ASSERT(a_status_code, p_status_code)
   `PLI_ASSERT(a_query_busy, req_valid && req_ready && (req_type == REQ_QUERY) |=> !req_ready)
   `PLI_ASSERT(a_rsp_from_query, $rose(rsp_valid) |-> $past(!req_ready))

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (.*);
